// ----- sv/tte_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the text terminal cursor engine
package tte_pkg;

	localparam int STORE_ROWS = 256;
	localparam int STORE_COLS = 128;

	localparam int ADDR_W = 5;

	// register indexes
	localparam logic [2:0] REG_COLUMNS = 3'd0;
	localparam logic [2:0] REG_ROWS    = 3'd1;
	localparam logic [2:0] REG_TAB     = 3'd2;
	localparam logic [2:0] REG_LOCK    = 3'd3;
	localparam logic [2:0] REG_DIRECT  = 3'd4;
	localparam logic [2:0] REG_VIEW    = 3'd5;

	// result kinds
	localparam logic [1:0] KIND_CELL  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_NONE  = 2'd2;

	// operations and character codes
	localparam logic       OP_PUT   = 1'b0;
	localparam logic       OP_MARK  = 1'b1;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;

	typedef struct packed {
		logic [7:0] columns_in_use;
		logic [6:0] rows_in_use;
		logic [4:0] tab_width;
		logic       lock_new_text;
		logic       direct_mode;
		logic [7:0] view_back_rows;
	} cfg_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       store_write;
		logic [7:0] store_row;
		logic [6:0] column;
		logic [7:0] cell_char;
		logic       cell_locked;
		logic       on_screen;
		logic [5:0] screen_row;
		logic [6:0] cursor_col_now;
		logic [5:0] cursor_row_now;
		logic [7:0] history_rows;
		logic       last;
	} out_item_t;

endpackage

// ----- sv/text_terminal_cursor_engine_top.sv -----
`timescale 1ns / 1ps
// top level of the text terminal cursor engine
//
//  channel  handshake                   payload       direction
//  item     item_valid / item_ready     in_item_t     in
//  res      res_valid / res_ready       out_item_t    out
//  apb      psel / penable / pready     pwdata/prdata in/out
//
// a printable passes the clamp and put states; a newline, backspace or mark passes
// the clamp and op states; a scroll adds a row clear, the only word of a newline
// a tab passes the clamp state, the shared remainder unit and the tab set state,
// then one space per cycle while the output has room, and a row clear per scroll
// arst_n clears cursor, ring start, prompt, history and the output valid flag
// a stalled res channel holds the sequencer; item_ready stays low until the last word
module text_terminal_cursor_engine_top import tte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  in_item_t          item,
	output logic              res_valid,
	input  logic              res_ready,
	output out_item_t         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t      cfg;
	logic      slot_free;
	logic      push;
	out_item_t push_data;

	tte_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tte_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.slot_free  (slot_free),
		.push       (push),
		.push_data  (push_data)
	);

	tte_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// ----- sv/tte_cfg_regs.sv -----
`timescale 1ns / 1ps
// apb register file of the cursor engine
module tte_cfg_regs import tte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.columns_in_use <= 8'd80;
			cfg_q.rows_in_use    <= 7'd25;
			cfg_q.tab_width      <= 5'd4;
			cfg_q.lock_new_text  <= 1'b0;
			cfg_q.direct_mode    <= 1'b0;
			cfg_q.view_back_rows <= 8'd0;
		end else if (wr) begin
			unique case (idx)
				REG_COLUMNS: cfg_q.columns_in_use <= pwdata[7:0];
				REG_ROWS:    cfg_q.rows_in_use    <= pwdata[6:0];
				REG_TAB:     cfg_q.tab_width      <= pwdata[4:0];
				REG_LOCK:    cfg_q.lock_new_text  <= pwdata[0];
				REG_DIRECT:  cfg_q.direct_mode    <= pwdata[0];
				REG_VIEW:    cfg_q.view_back_rows <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COLUMNS: prdata = {24'd0, cfg_q.columns_in_use};
			REG_ROWS:    prdata = {25'd0, cfg_q.rows_in_use};
			REG_TAB:     prdata = {27'd0, cfg_q.tab_width};
			REG_LOCK:    prdata = {31'd0, cfg_q.lock_new_text};
			REG_DIRECT:  prdata = {31'd0, cfg_q.direct_mode};
			REG_VIEW:    prdata = {24'd0, cfg_q.view_back_rows};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

// ----- sv/tte_sub.sv -----
`timescale 1ns / 1ps
// shared subtract and compare unit for tab stop arithmetic
module tte_sub (
	input  logic [4:0] a,
	input  logic [4:0] b,
	output logic [4:0] diff,
	output logic       ge
);

	logic [5:0] d;

	assign d    = {1'b0, a} - {1'b0, b};
	assign ge   = ~d[5];
	assign diff = d[4:0];

endmodule

// ----- sv/tte_out_reg.sv -----
`timescale 1ns / 1ps
// output register holding one result word
module tte_out_reg import tte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      slot_free,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

	logic      valid_q;
	out_item_t data_q;

	assign slot_free = ~valid_q | res_ready;
	assign res_valid = valid_q;
	assign res       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule

// ----- sv/tte_seq.sv -----
`timescale 1ns / 1ps
// sequencer with cursor, ring and prompt state
module tte_seq import tte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      item_valid,
	input  in_item_t  item,
	output logic      item_ready,
	input  logic      slot_free,
	output logic      push,
	output out_item_t push_data
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CLAMP  = 3'd1;
	localparam logic [2:0] S_MOD    = 3'd2;
	localparam logic [2:0] S_TABSET = 3'd3;
	localparam logic [2:0] S_PUT    = 3'd4;
	localparam logic [2:0] S_SCROLL = 3'd5;
	localparam logic [2:0] S_OP     = 3'd6;

	localparam logic [7:0] COL_MAX = (STORE_COLS < 128) ? 8'(STORE_COLS) : 8'd128;

	logic [2:0] state_q, nxt_state;
	logic [6:0] cursor_col_q, nxt_col;
	logic [5:0] cursor_row_q, nxt_row;
	logic [7:0] ring_start_q, nxt_ring;
	logic [6:0] prompt_col_q, nxt_pcol;
	logic [5:0] prompt_row_q, nxt_prow;
	logic [7:0] history_q, nxt_hist;
	logic [4:0] cnt_q, nxt_cnt;
	logic [3:0] rem_q, nxt_rem;
	logic [2:0] bit_q, nxt_bit;
	logic       op_q;
	logic [7:0] ch_q;

	logic [7:0]  cols_eff;
	logic [6:0]  rows_eff;
	logic [4:0]  tab_eff;
	logic [10:0] cap_w;
	logic [7:0]  cap;
	logic [7:0]  hist_inc;
	logic [7:0]  ring_inc;
	logic [7:0]  col_inc;
	logic        wrap;
	logic [6:0]  row_mid;
	logic        scroll;
	logic [6:0]  nl_row;
	logic        nl_scroll;
	logic [6:0]  bs_col;
	logic [5:0]  bs_row;
	logic        bs_moved;
	logic [6:0]  put_view;
	logic [6:0]  bs_view;
	logic [7:0]  put_char;
	logic        view_top;

	logic [4:0] sub_a, sub_b, sub_diff;
	logic       sub_ge;

	tte_sub u_sub (
		.a    (sub_a),
		.b    (sub_b),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	function automatic logic [7:0] ring_row(input logic [7:0] base, input logic [6:0] r);
		logic [8:0] s;
		s = {1'b0, base} + {2'b0, r};
		if (s >= 9'(STORE_ROWS)) begin
			s = s - 9'(STORE_ROWS);
		end
		return s[7:0];
	endfunction

	// returns {on_screen, screen_row}
	function automatic logic [6:0] view_of(input logic [5:0] row, input logic direct,
			input logic [7:0] back, input logic [6:0] rows);
		logic [8:0] sy;
		logic       on;
		sy = {3'b0, row} + (direct ? 9'd0 : {1'b0, back});
		on = (sy < {2'b0, rows});
		return {on, on ? sy[5:0] : 6'd0};
	endfunction

	always_comb begin
		cols_eff = cfg.columns_in_use;
		if (cfg.columns_in_use == 8'd0 || cfg.columns_in_use > COL_MAX) begin
			cols_eff = COL_MAX;
		end
		rows_eff = cfg.rows_in_use;
		if (cfg.rows_in_use == 7'd0) begin
			rows_eff = 7'd1;
		end else if (cfg.rows_in_use > 7'd64) begin
			rows_eff = 7'd64;
		end
		tab_eff = cfg.tab_width;
		if (cfg.tab_width == 5'd0) begin
			tab_eff = 5'd1;
		end else if (cfg.tab_width > 5'd16) begin
			tab_eff = 5'd16;
		end
	end

	assign cap_w    = 11'(STORE_ROWS) - {4'b0, rows_eff};
	assign cap      = (cap_w > 11'd255) ? 8'd255 : cap_w[7:0];
	assign hist_inc = (history_q < cap) ? history_q + 8'd1 : history_q;
	assign ring_inc = ring_row(ring_start_q, 7'd1);
	assign view_top = (cfg.view_back_rows == 8'd0);

	// character put
	assign col_inc  = {1'b0, cursor_col_q} + 8'd1;
	assign wrap     = (col_inc >= cols_eff);
	assign row_mid  = {1'b0, cursor_row_q} + {6'd0, wrap};
	assign scroll   = (row_mid >= rows_eff);
	assign put_view = view_of(cursor_row_q, cfg.direct_mode, cfg.view_back_rows, rows_eff);
	assign put_char = (ch_q == CH_TAB) ? CH_SPACE : ch_q;

	// newline
	assign nl_row    = {1'b0, cursor_row_q} + 7'd1;
	assign nl_scroll = (nl_row >= rows_eff);

	// backspace with prompt guard and reverse wrap
	always_comb begin
		bs_col   = cursor_col_q;
		bs_row   = cursor_row_q;
		bs_moved = 1'b0;
		if (cursor_col_q != 7'd0) begin
			if (!(cursor_row_q == prompt_row_q && cursor_col_q <= prompt_col_q)) begin
				bs_col   = cursor_col_q - 7'd1;
				bs_moved = 1'b1;
			end
		end else if (cursor_row_q > prompt_row_q) begin
			bs_row   = cursor_row_q - 6'd1;
			bs_col   = 7'(cols_eff - 8'd1);
			bs_moved = 1'b1;
		end
	end
	assign bs_view = view_of(bs_row, cfg.direct_mode, cfg.view_back_rows, rows_eff);

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		nxt_state = state_q;
		nxt_col   = cursor_col_q;
		nxt_row   = cursor_row_q;
		nxt_ring  = ring_start_q;
		nxt_pcol  = prompt_col_q;
		nxt_prow  = prompt_row_q;
		nxt_hist  = history_q;
		nxt_cnt   = cnt_q;
		nxt_rem   = rem_q;
		nxt_bit   = bit_q;
		sub_a     = 5'd0;
		sub_b     = 5'd0;
		push      = 1'b0;
		push_data = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					nxt_state = S_CLAMP;
				end
			end
			S_CLAMP: begin
				// shrunk geometry pulls the cursor back inside
				if ({1'b0, cursor_col_q} >= cols_eff) begin
					nxt_col = 7'(cols_eff - 8'd1);
				end
				if ({1'b0, cursor_row_q} >= rows_eff) begin
					nxt_row = 6'(rows_eff - 7'd1);
				end
				nxt_cnt = 5'd1;
				nxt_rem = 4'd0;
				nxt_bit = 3'd6;
				if (op_q == OP_MARK || ch_q == CH_BS || ch_q == CH_NL) begin
					nxt_state = S_OP;
				end else if (ch_q == CH_TAB) begin
					nxt_state = S_MOD;
				end else begin
					nxt_state = S_PUT;
				end
			end
			S_MOD: begin
				// restoring remainder, one column bit a cycle
				sub_a = {rem_q, cursor_col_q[bit_q]};
				sub_b = tab_eff;
				nxt_rem = sub_ge ? sub_diff[3:0] : sub_a[3:0];
				nxt_bit = bit_q - 3'd1;
				if (bit_q == 3'd0) begin
					nxt_state = S_TABSET;
				end
			end
			S_TABSET: begin
				sub_a     = tab_eff;
				sub_b     = {1'b0, rem_q};
				nxt_cnt   = sub_diff;
				nxt_state = S_PUT;
			end
			S_PUT: begin
				if (slot_free) begin
					push    = 1'b1;
					nxt_col = wrap ? 7'd0 : col_inc[6:0];
					nxt_row = scroll ? 6'(row_mid - 7'd1) : row_mid[5:0];
					if (scroll) begin
						nxt_hist = hist_inc;
						nxt_ring = ring_inc;
					end
					nxt_cnt = cnt_q - 5'd1;
					push_data.kind           = KIND_CELL;
					push_data.store_write    = ~cfg.direct_mode;
					push_data.store_row      = ring_row(ring_start_q, {1'b0, cursor_row_q});
					push_data.column         = cursor_col_q;
					push_data.cell_char      = put_char;
					push_data.cell_locked    = cfg.lock_new_text;
					push_data.on_screen      = put_view[6];
					push_data.screen_row     = put_view[5:0];
					push_data.cursor_col_now = nxt_col;
					push_data.cursor_row_now = nxt_row;
					push_data.history_rows   = nxt_hist;
					push_data.last           = ~scroll & (cnt_q == 5'd1);
					if (scroll) begin
						nxt_state = S_SCROLL;
					end else if (cnt_q == 5'd1) begin
						nxt_state = S_IDLE;
					end
				end
			end
			S_SCROLL: begin
				// ring start and history already advanced
				if (slot_free) begin
					push = 1'b1;
					if (prompt_row_q != 6'd0) begin
						nxt_prow = prompt_row_q - 6'd1;
					end else begin
						nxt_pcol = 7'd0;
					end
					push_data.kind           = KIND_CLEAR;
					push_data.store_write    = 1'b1;
					push_data.store_row      = ring_row(ring_start_q, rows_eff - 7'd1);
					push_data.column         = 7'd0;
					push_data.cell_char      = CH_SPACE;
					push_data.cell_locked    = 1'b0;
					push_data.on_screen      = view_top;
					push_data.screen_row     = view_top ? 6'(rows_eff - 7'd1) : 6'd0;
					push_data.cursor_col_now = cursor_col_q;
					push_data.cursor_row_now = cursor_row_q;
					push_data.history_rows   = history_q;
					push_data.last           = (cnt_q == 5'd0);
					nxt_state = (cnt_q == 5'd0) ? S_IDLE : S_PUT;
				end
			end
			S_OP: begin
				if (slot_free) begin
					nxt_state = S_IDLE;
					push      = 1'b1;
					push_data.kind = KIND_NONE;
					push_data.last = 1'b1;
					if (op_q == OP_MARK) begin
						nxt_pcol = cursor_col_q;
						nxt_prow = cursor_row_q;
					end else if (ch_q == CH_NL) begin
						nxt_col = 7'd0;
						if (nl_scroll) begin
							// only the row clear goes out
							push      = 1'b0;
							nxt_hist  = hist_inc;
							nxt_ring  = ring_inc;
							nxt_cnt   = 5'd0;
							nxt_state = S_SCROLL;
						end else begin
							nxt_row = nl_row[5:0];
						end
					end else if (bs_moved) begin
						nxt_col = bs_col;
						nxt_row = bs_row;
						push_data.kind        = KIND_CELL;
						push_data.store_write = ~cfg.direct_mode;
						push_data.store_row   = ring_row(ring_start_q, {1'b0, bs_row});
						push_data.column      = bs_col;
						push_data.cell_char   = CH_SPACE;
						push_data.on_screen   = bs_view[6];
						push_data.screen_row  = bs_view[5:0];
					end
					push_data.cursor_col_now = nxt_col;
					push_data.cursor_row_now = nxt_row;
					push_data.history_rows   = history_q;
				end
			end
			default: nxt_state = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cursor_col_q <= 7'd0;
			cursor_row_q <= 6'd0;
			ring_start_q <= 8'd0;
			prompt_col_q <= 7'd0;
			prompt_row_q <= 6'd0;
			history_q    <= 8'd0;
			cnt_q        <= 5'd0;
			rem_q        <= 4'd0;
			bit_q        <= 3'd0;
		end else begin
			state_q      <= nxt_state;
			cursor_col_q <= nxt_col;
			cursor_row_q <= nxt_row;
			ring_start_q <= nxt_ring;
			prompt_col_q <= nxt_pcol;
			prompt_row_q <= nxt_prow;
			history_q    <= nxt_hist;
			cnt_q        <= nxt_cnt;
			rem_q        <= nxt_rem;
			bit_q        <= nxt_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_q <= item.operation;
			ch_q <= item.char_code;
		end
	end

	a_put_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> ({1'b0, cursor_col_q} < cols_eff && {1'b0, cursor_row_q} < rows_eff))
		else $error("cursor outside visible area while putting a cell");

	a_put_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> (cnt_q != 5'd0))
		else $error("put without pending spaces");

	a_scroll_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_SCROLL) |-> ($past(state_q) == S_PUT || $past(state_q) == S_OP))
		else $error("scroll entered from an unexpected state");

	a_rem_below_tab: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TABSET) |-> ({1'b0, rem_q} < tab_eff))
		else $error("tab remainder not below tab width");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> slot_free)
		else $error("result word pushed into a full output register");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// testbench of the text terminal cursor engine: directed and random text checked against a predictor
module tb_top;
	import tte_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int END_CYCLES    = 20;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	in_item_t          item;
	logic              res_valid;
	logic              res_ready;
	out_item_t         res;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	text_terminal_cursor_engine_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// terminal state as the block should hold it
	cfg_t        term_cfg;
	int unsigned cur_col;
	int unsigned cur_row;
	int unsigned ring_base;
	int unsigned prompt_col;
	int unsigned prompt_row;
	int unsigned kept_rows;

	out_item_t step_words[$];
	out_item_t expected_words[$];

	int mismatches;
	int idle_cycles;
	bit tx_idle;
	bit rx_idle;
	int sink_hold;

	function automatic int unsigned text_cols();
		int unsigned c;
		c = term_cfg.columns_in_use;
		if (c == 0 || c > STORE_COLS) c = STORE_COLS;
		if (c > 128) c = 128;
		return c;
	endfunction

	function automatic int unsigned text_rows();
		int unsigned r;
		r = term_cfg.rows_in_use;
		if (r == 0) r = 1;
		if (r > 64) r = 64;
		return r;
	endfunction

	function automatic int unsigned tab_spacing();
		int unsigned t;
		t = term_cfg.tab_width;
		if (t == 0) t = 1;
		if (t > 16) t = 16;
		return t;
	endfunction

	function automatic logic [7:0] ring_row(int unsigned r);
		return 8'((ring_base + r) % STORE_ROWS);
	endfunction

	function automatic void add_word(logic [1:0] kind, logic sw, logic [7:0] row,
			logic [6:0] col, logic [7:0] ch, logic lk, logic vis, logic [5:0] srow);
		out_item_t w;
		w = '0;
		w.kind        = kind;
		w.store_write = sw;
		w.store_row   = row;
		w.column      = col;
		w.cell_char   = ch;
		w.cell_locked = lk;
		w.on_screen   = vis;
		w.screen_row  = srow;
		step_words.push_back(w);
	endfunction

	function automatic void stamp_cursor(int from);
		for (int k = from; k < step_words.size(); k++) begin
			step_words[k].cursor_col_now = cur_col[6:0];
			step_words[k].cursor_row_now = cur_row[5:0];
			step_words[k].history_rows   = kept_rows[7:0];
		end
	endfunction

	function automatic void scroll_up();
		int unsigned rows;
		int unsigned cap;
		logic vis;
		rows = text_rows();
		cap = STORE_ROWS - rows;
		if (cap > 255) cap = 255;
		if (kept_rows < cap) kept_rows++;
		ring_base = (ring_base + 1) % STORE_ROWS;
		vis = (term_cfg.view_back_rows == 0);
		add_word(KIND_CLEAR, 1'b1, ring_row(rows - 1), '0, CH_SPACE, 1'b0, vis,
			vis ? 6'(rows - 1) : 6'd0);
		if (prompt_row > 0) begin
			prompt_row--;
		end else begin
			prompt_col = 0;
		end
	endfunction

	function automatic void cell_view(output logic vis, output logic [5:0] srow);
		int unsigned sy;
		sy = cur_row + (term_cfg.direct_mode ? 0 : term_cfg.view_back_rows);
		vis = (sy < text_rows());
		srow = vis ? 6'(sy) : 6'd0;
	endfunction

	function automatic void write_cell(logic [7:0] ch, logic lk);
		int first;
		logic vis;
		logic [5:0] srow;
		first = step_words.size();
		cell_view(vis, srow);
		add_word(KIND_CELL, !term_cfg.direct_mode, ring_row(cur_row), cur_col[6:0], ch, lk,
			vis, srow);
		cur_col++;
		if (cur_col >= text_cols()) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= text_rows()) begin
			scroll_up();
			cur_row--;
		end
		stamp_cursor(first);
	endfunction

	// works out every word that one accepted item must produce
	function automatic void predict_item(in_item_t it);
		int unsigned cols;
		int unsigned rows;
		int unsigned spaces;
		bit moved;
		logic vis;
		logic [5:0] srow;
		step_words.delete();
		cols = text_cols();
		rows = text_rows();
		// geometry may have shrunk under the cursor
		if (cur_col >= cols) cur_col = cols - 1;
		if (cur_row >= rows) cur_row = rows - 1;
		if (it.operation == OP_MARK) begin
			prompt_col = cur_col;
			prompt_row = cur_row;
		end else if (it.char_code == CH_BS) begin
			moved = 1'b0;
			if (cur_col > 0) begin
				if (!(cur_row == prompt_row && cur_col <= prompt_col)) begin
					cur_col--;
					moved = 1'b1;
				end
			end else if (cur_row > prompt_row) begin
				cur_row--;
				cur_col = cols - 1;
				moved = 1'b1;
			end
			if (moved) begin
				cell_view(vis, srow);
				add_word(KIND_CELL, !term_cfg.direct_mode, ring_row(cur_row), cur_col[6:0],
					CH_SPACE, 1'b0, vis, srow);
				stamp_cursor(0);
			end
		end else if (it.char_code == CH_TAB) begin
			spaces = tab_spacing() - (cur_col % tab_spacing());
			repeat (spaces) write_cell(CH_SPACE, term_cfg.lock_new_text);
		end else if (it.char_code == CH_NL) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= rows) begin
				scroll_up();
				cur_row--;
			end
			stamp_cursor(0);
		end else begin
			write_cell(it.char_code, term_cfg.lock_new_text);
		end
		if (step_words.size() == 0) begin
			add_word(KIND_NONE, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0);
			stamp_cursor(0);
		end
		step_words[step_words.size() - 1].last = 1'b1;
		foreach (step_words[k]) expected_words.push_back(step_words[k]);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : word_checker
		out_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_words.size() == 0) begin
				$error("word with nothing expected: kind %0d row %0d col %0d char %0d",
					res.kind, res.store_row, res.column, res.cell_char);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				check_field("kind", want.kind, res.kind);
				check_field("store_write", want.store_write, res.store_write);
				check_field("store_row", want.store_row, res.store_row);
				check_field("column", want.column, res.column);
				check_field("cell_char", want.cell_char, res.cell_char);
				check_field("cell_locked", want.cell_locked, res.cell_locked);
				check_field("on_screen", want.on_screen, res.on_screen);
				check_field("screen_row", want.screen_row, res.screen_row);
				check_field("cursor_col_now", want.cursor_col_now, res.cursor_col_now);
				check_field("cursor_row_now", want.cursor_row_now, res.cursor_row_now);
				check_field("history_rows", want.history_rows, res.history_rows);
				check_field("last", want.last, res.last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result sink: random gaps per word when rx_idle is set, plus a long hold-off when asked
	initial begin : word_sink
		int gap;
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = rx_idle ? $urandom_range(0, 5) : 0;
			if (sink_hold > 0) begin
				gap = sink_hold;
				sink_hold = 0;
			end
			repeat (gap) begin
				@(negedge clk);
				res_ready <= 1'b0;
			end
			@(negedge clk);
			res_ready <= 1'b1;
			do @(posedge clk); while (!(res_valid && res_ready));
		end
	end

	// valid stays high after acceptance until the next item or drain_words
	task automatic send_item(input logic op, input logic [7:0] ch);
		int gap;
		in_item_t it;
		it.operation = op;
		it.char_code = ch;
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!(item_valid && item_ready));
		predict_item(it);
	endtask

	task automatic put_text(input string s);
		for (int k = 0; k < s.len(); k++) send_item(OP_PUT, s[k]);
	endtask

	task automatic drain_words();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the engine idle
	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_COLUMNS: term_cfg.columns_in_use = value[7:0];
			REG_ROWS:    term_cfg.rows_in_use    = value[6:0];
			REG_TAB:     term_cfg.tab_width      = value[4:0];
			REG_LOCK:    term_cfg.lock_new_text  = value[0];
			REG_DIRECT:  term_cfg.direct_mode    = value[0];
			REG_VIEW:    term_cfg.view_back_rows = value[7:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic cfg_all(input logic [7:0] cols, input logic [6:0] rows, input logic [4:0] tab,
			input logic lk, input logic direct, input logic [7:0] view);
		cfg_write(REG_COLUMNS, cols);
		cfg_write(REG_ROWS, rows);
		cfg_write(REG_TAB, tab);
		cfg_write(REG_LOCK, lk);
		cfg_write(REG_DIRECT, direct);
		cfg_write(REG_VIEW, view);
	endtask

	task automatic test_defaults();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_item(OP_PUT, 8'h41);
		send_item(OP_PUT, 8'h00);
		send_item(OP_PUT, 8'hFF);
		send_item(OP_PUT, 8'h7F);
		send_item(OP_MARK, 8'hFF);
		send_item(OP_PUT, CH_BS);
		send_item(OP_PUT, 8'h62);
		send_item(OP_PUT, CH_BS);
		send_item(OP_PUT, CH_TAB);
		send_item(OP_PUT, CH_NL);
		send_item(OP_PUT, 8'h0B);
		send_item(OP_PUT, 8'h07);
		drain_words();
	endtask

	task automatic test_prompt_backspace();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		cfg_all(8'd4, 7'd3, 5'd2, 1'b1, 1'b0, 8'd0);
		send_item(OP_PUT, CH_NL);
		send_item(OP_MARK, 8'h00);
		put_text("abcde");
		// steps back across the wrap, then stops at the prompt
		repeat (6) send_item(OP_PUT, CH_BS);
		put_text("xy");
		repeat (3) send_item(OP_PUT, CH_NL);
		repeat (2) send_item(OP_PUT, CH_BS);
		drain_words();
	endtask

	task automatic test_history_fill();
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		// one cell screen: each tab space wraps and scrolls, history saturates
		cfg_all(8'd1, 7'd1, 5'd31, 1'b0, 1'b0, 8'd0);
		repeat (17) send_item(OP_PUT, CH_TAB);
		drain_words();
		cfg_write(REG_VIEW, 8'd255);
		send_item(OP_PUT, CH_TAB);
		send_item(OP_PUT, 8'h5A);
		drain_words();
	endtask

	task automatic test_odd_geometry();
		tx_idle = 1'b1;
		rx_idle = 1'b0;
		cfg_all(8'd0, 7'd0, 5'd0, 1'b0, 1'b0, 8'd0);
		put_text("x");
		send_item(OP_PUT, CH_TAB);
		send_item(OP_PUT, CH_NL);
		drain_words();
		cfg_all(8'd200, 7'd127, 5'd20, 1'b1, 1'b0, 8'd1);
		send_item(OP_PUT, CH_TAB);
		repeat (3) send_item(OP_PUT, CH_NL);
		send_item(OP_PUT, CH_TAB);
		drain_words();
		// shrink below the cursor
		cfg_write(REG_COLUMNS, 8'd2);
		cfg_write(REG_ROWS, 7'd2);
		put_text("B");
		send_item(OP_PUT, CH_BS);
		drain_words();
	endtask

	task automatic test_direct_view();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		cfg_all(8'd8, 7'd4, 5'd3, 1'b1, 1'b1, 8'd2);
		put_text("q");
		send_item(OP_PUT, CH_TAB);
		repeat (4) send_item(OP_PUT, CH_NL);
		send_item(OP_PUT, CH_BS);
		drain_words();
		cfg_write(REG_DIRECT, 1'b0);
		put_text("r");
		send_item(OP_PUT, CH_BS);
		send_item(OP_PUT, CH_NL);
		drain_words();
	endtask

	task automatic test_output_stall();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		cfg_all(8'd5, 7'd2, 5'd4, 1'b0, 1'b0, 8'd0);
		sink_hold = 150;
		put_text("stall");
		send_item(OP_PUT, CH_TAB);
		drain_words();
	endtask

	task automatic test_random_text();
		logic [7:0] cols;
		logic [6:0] rows;
		logic [7:0] view;
		logic [7:0] ch;
		logic op;
		int pick;
		for (int phase = 0; phase < 5; phase++) begin
			tx_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
			rx_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 5))
				0: cols = 8'd1;
				1: cols = 8'd2;
				2: cols = 8'($urandom_range(3, 12));
				3: cols = 8'd80;
				4: cols = 8'd128;
				default: cols = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(129, 255));
			endcase
			case ($urandom_range(0, 5))
				0: rows = 7'd1;
				1: rows = 7'd2;
				2: rows = 7'($urandom_range(3, 8));
				3: rows = 7'd64;
				4: rows = 7'($urandom_range(65, 127));
				default: rows = 7'd0;
			endcase
			case ($urandom_range(0, 3))
				0: view = 8'd0;
				1: view = 8'd255;
				default: view = 8'($urandom_range(0, 70));
			endcase
			cfg_all(cols, rows, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), view);
			repeat (16) begin
				pick = $urandom_range(0, 99);
				op = OP_PUT;
				ch = 8'($urandom_range(0, 255));
				if (pick < 6) op = OP_MARK;
				else if (pick < 22) ch = CH_BS;
				else if (pick < 32) ch = CH_TAB;
				else if (pick < 42) ch = CH_NL;
				send_item(op, ch);
			end
			drain_words();
		end
	endtask

	initial begin : test_sequence
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		mismatches = 0;
		sink_hold  = 0;
		tx_idle    = 1'b0;
		rx_idle    = 1'b0;
		term_cfg.columns_in_use = 8'd80;
		term_cfg.rows_in_use    = 7'd25;
		term_cfg.tab_width      = 5'd4;
		term_cfg.lock_new_text  = 1'b0;
		term_cfg.direct_mode    = 1'b0;
		term_cfg.view_back_rows = 8'd0;
		cur_col    = 0;
		cur_row    = 0;
		ring_base  = 0;
		prompt_col = 0;
		prompt_row = 0;
		kept_rows  = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_prompt_backspace();
		test_history_fill();
		test_odd_geometry();
		test_direct_view();
		test_output_stall();
		test_random_text();

		drain_words();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
